>>> rtl/core/open_addressing_hash_map_defines.svh
// Assertion macros for the open addressing hash map.
// Included by the top level; expects clock and reset in scope.
`ifndef OPEN_ADDRESSING_HASH_MAP_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_MAP_DEFINES_SVH

// same-cycle implication
`define HMAP_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hash map check failed");

// next-cycle implication
`define HMAP_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hash map sequencing check failed");

`endif

>>> rtl/core/hmap_pkg.sv
// Shared types and constants of the hash map.
// No dependencies.
package hmap_pkg;

   localparam int KEY_W      = 32;
   localparam int HASH_W     = 32;
   localparam int VAL_W      = 64;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 4;

   // hash reduction: bits folded into the remainder per cycle
   localparam int STEP_BITS  = 4;
   localparam int MOD_STEPS  = HASH_W / STEP_BITS;
   localparam int STEP_CNT_W = $clog2(MOD_STEPS);

   localparam int LOAD_NUM = 80;
   localparam int LOAD_DEN = 100;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } slot_entry_type;

   typedef struct packed {
      logic load;          // take hash, clear remainder
      logic reduce;        // fold next hash digit
      logic probe_start;   // load start slot
      logic probe_run;     // issue read, compare previous beat
   } prb_ctrl_type;

   typedef struct packed {
      logic stop;
      logic found;
   } prb_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_START,
      ST_PROBE,
      ST_COMMIT
   } hmap_state_type;

endpackage

>>> rtl/core/hmap_req_if.sv
// Request channel: valid/ready plus one request beat.
// Depends on hmap_pkg.
interface hmap_req_if import hmap_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [KEY_W-1:0]   key;
   logic [HASH_W-1:0]  key_hash;
   logic [VAL_W-1:0]   value;

   modport source (output valid, operation, key, key_hash, value, input ready);
   modport sink   (input valid, operation, key, key_hash, value, output ready);
endinterface

>>> rtl/core/hmap_rsp_if.sv
// Response channel: valid/ready plus one response beat.
// Depends on hmap_pkg.
interface hmap_rsp_if import hmap_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [VAL_W-1:0]      result_value;
   logic [SLOT_OUT_W-1:0] slot_index;
   logic                  was_update;
   logic                  load_limit_reached;

   modport source (output valid, status, result_value, slot_index, was_update,
                   load_limit_reached, input ready);
   modport sink   (input valid, status, result_value, slot_index, was_update,
                   load_limit_reached, output ready);
endinterface

>>> rtl/core/open_addressing_hash_map.sv
// Open addressing hash map, linear probing over SLOTS slots.
// A request passes hash reduction, start, probe reads over k slots (k = slots probed,
// 1..SLOTS), commit and the response register before its response beat.
// One request at a time: the next beat is taken the cycle after commit.
// Reset: synchronous; a clearing pass over all SLOTS slots empties the table, with
// req_bus.ready low meanwhile. Response beat waits in an output register.
`include "open_addressing_hash_map_defines.svh"

module open_addressing_hash_map import hmap_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   hmap_req_if.sink    req_bus,
   hmap_rsp_if.source  rsp_bus
);

   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int LOAD_LIMIT = SLOTS * LOAD_NUM / LOAD_DEN;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // ---------------------------------------------------------------
   // sequencer state
   // ---------------------------------------------------------------
   hmap_state_type          state_ff, state_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic [STEP_CNT_W-1:0]   step_ff, step_in;

   // captured request beat (hash goes straight into the prober on accept)
   logic                    op_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [VAL_W-1:0]        value_ff;

   // probe outcome, held for the commit cycle
   logic                    fnd_ff;
   logic                    fused_ff;
   logic [IDX_W-1:0]        fpos_ff;
   logic [VAL_W-1:0]        fval_ff;

   logic [CNT_W-1:0]        used_count_ff, used_count_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [VAL_W-1:0]        rsp_value_ff;
   logic [SLOT_OUT_W-1:0]   rsp_slot_ff;
   logic                    rsp_upd_ff;
   logic                    rsp_load_ff;

   // control
   prb_ctrl_type            prb_ctrl;
   prb_status_type          prb_status;
   logic                    req_accept;
   logic                    in_commit;
   logic                    commit_go;
   logic                    grow;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   slot_entry_type          wr_data;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   slot_entry_type          rd_data;
   logic [IDX_W-1:0]        stop_pos;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign in_commit  = (state_ff == ST_COMMIT);
   // commit only once the response register is free or draining this cycle
   assign commit_go  = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_bus.ready);
   // insert into an empty slot raises the count
   assign grow       = commit_go && (op_ff == OP_INSERT) && fnd_ff && !fused_ff;

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (step_ff == STEP_CNT_W'(MOD_STEPS - 1)) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (prb_status.stop) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // outputs of the sequencer
   // ---------------------------------------------------------------
   always_comb begin
      prb_ctrl      = '0;
      req_bus.ready = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = fpos_ff;
      wr_data       = '{used: 1'b1, key: key_ff, value: value_ff};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            prb_ctrl.load = 1'b1;
         end
         ST_REDUCE: begin
            prb_ctrl.reduce = 1'b1;
         end
         ST_START: begin
            prb_ctrl.probe_start = 1'b1;
         end
         ST_PROBE: begin
            prb_ctrl.probe_run = 1'b1;
         end
         ST_COMMIT: begin
            // both update and fresh insert write the full entry
            wr_en = commit_go && (op_ff == OP_INSERT) && fnd_ff;
         end
         default: begin
            prb_ctrl = '0;
         end
      endcase
   end

   // load is harmless when idle without a beat: hash is reloaded on accept
   always_comb begin
      clr_in = clr_ff;
      step_in = step_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end
      if (state_ff == ST_REDUCE) begin
         step_in = step_ff + 1'b1;
      end else begin
         step_in = '0;
      end
   end

   assign used_count_in = grow ? used_count_ff + 1'b1 : used_count_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         step_ff       <= '0;
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         step_ff       <= step_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_bus.operation;
         key_ff   <= req_bus.key;
         value_ff <= req_bus.value;
      end
      if ((state_ff == ST_PROBE) && prb_status.stop) begin
         fnd_ff   <= prb_status.found;
         fused_ff <= rd_data.used;
         fpos_ff  <= prb_status.found ? stop_pos : '0;
         fval_ff  <= rd_data.value;
      end
   end

   // response beat
   always_ff @(posedge clock) begin
      if (commit_go) begin
         rsp_slot_ff  <= SLOT_OUT_W'(fpos_ff);
         rsp_load_ff  <= (used_count_in >= CNT_W'(LOAD_LIMIT));
         rsp_upd_ff   <= (op_ff == OP_INSERT) && fnd_ff && fused_ff;
         rsp_value_ff <= '0;
         if (op_ff == OP_LOOKUP) begin
            if (fnd_ff && fused_ff) begin
               rsp_status_ff <= STATUS_OK;
               rsp_value_ff  <= fval_ff;
            end else begin
               rsp_status_ff <= STATUS_MISS;
            end
         end else begin
            rsp_status_ff <= fnd_ff ? STATUS_OK : STATUS_FULL;
         end
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.status             = rsp_status_ff;
   assign rsp_bus.result_value       = rsp_value_ff;
   assign rsp_bus.slot_index         = rsp_slot_ff;
   assign rsp_bus.was_update         = rsp_upd_ff;
   assign rsp_bus.load_limit_reached = rsp_load_ff;

   // ---------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------
   hmap_prober #(
      .SLOTS(SLOTS)
   ) u_prober (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (prb_ctrl),
      .hash_in  (req_bus.key_hash),
      .key_in   (key_ff),
      .rd_data  (rd_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .stop_pos (stop_pos),
      .status   (prb_status)
   );

   hmap_slot_ram #(
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `HMAP_CHECK(a_count_bound, 1'b1, used_count_ff <= CNT_W'(SLOTS))
   `HMAP_CHECK(a_count_from_commit, !$past(reset) && $changed(used_count_ff), $past(in_commit))
   `HMAP_CHECK(a_rsp_from_commit, !$past(reset) && $rose(rsp_valid_ff), $past(commit_go))
   `HMAP_CHECK_NEXT(a_commit_leaves, commit_go, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

>>> rtl/core/hmap_slot_ram.sv
// Slot storage: one write port, one read port with registered data.
// Depends on hmap_pkg.
module hmap_slot_ram import hmap_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  slot_entry_type           wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output slot_entry_type           rd_data
);

   slot_entry_type mem [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hmap_prober.sv
// Probe unit: hash reduction mod SLOTS, probe address walk, slot compare.
// Depends on hmap_pkg; reads through hmap_slot_ram.
module hmap_prober import hmap_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  prb_ctrl_type             ctrl,
   input  logic [HASH_W-1:0]        hash_in,
   input  logic [KEY_W-1:0]         key_in,
   input  slot_entry_type           rd_data,
   output logic                     rd_en,
   output logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [$clog2(SLOTS)-1:0] stop_pos,
   output prb_status_type           status
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W+1)'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

   logic [HASH_W-1:0] hash_ff, hash_in_nx;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  seen_ff, seen_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rem_step;
   logic              hit;

   // restoring remainder, STEP_BITS hash bits per cycle
   always_comb begin
      logic [IDX_W-1:0] r;
      logic [IDX_W:0]   t;
      r = rem_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         t = {r, hash_ff[HASH_W-1-i]};
         if (t >= SLOTS_EXT) begin
            t = t - SLOTS_EXT;
         end
         r = t[IDX_W-1:0];
      end
      rem_step = r;
   end

   assign hit = !rd_data.used || (rd_data.key == key_in);

   always_comb begin
      hash_in_nx = hash_ff;
      rem_in     = rem_ff;
      addr_in    = addr_ff;
      pos_in     = pos_ff;
      seen_in    = seen_ff;
      rd_vld_in  = rd_vld_ff;
      if (ctrl.load) begin
         hash_in_nx = hash_in;
         rem_in     = '0;
      end else if (ctrl.reduce) begin
         hash_in_nx = hash_ff << STEP_BITS;
         rem_in     = rem_step;
      end else if (ctrl.probe_start) begin
         addr_in   = rem_ff;
         seen_in   = '0;
         rd_vld_in = 1'b0;
      end else if (ctrl.probe_run) begin
         addr_in   = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
         pos_in    = addr_ff;
         rd_vld_in = 1'b1;
         if (rd_vld_ff) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in_nx;
      rem_ff  <= rem_in;
      addr_ff <= addr_in;
      pos_ff  <= pos_in;
      seen_ff <= seen_in;
   end

   assign rd_en        = ctrl.probe_run;
   assign rd_addr      = addr_ff;
   assign stop_pos     = pos_ff;
   assign status.found = rd_vld_ff && hit;
   assign status.stop  = rd_vld_ff && (hit || (seen_ff == LAST_IDX));

endmodule

>>> sim/open_addressing_hash_map_tb.sv
// Self-checking bench for open_addressing_hash_map: directed and random lookups and inserts
// are scored against a linear probing table model kept inside the bench.
// Depends on hmap_pkg, hmap_req_if, hmap_rsp_if and the RTL top level.
module open_addressing_hash_map_tb;
   import hmap_pkg::*;

   localparam int SLOTS        = 16;
   localparam int LOAD_LIMIT   = SLOTS * LOAD_NUM / LOAD_DEN;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 7;
   // longest response: reduction, start, probe reads over every slot, commit, response register
   localparam int MAX_LATENCY  = 12 + SLOTS;
   localparam int RANDOM_ITEMS = 1027;
   localparam int QUIET_TAIL   = 150;   // last random beats run with no idling
   localparam int LONG_HOLD    = 300;   // cycles the response side refuses beats
   localparam int HOLD_AT      = 300;
   localparam int DRAIN_AT     = 650;
   localparam int MAX_REPORTS  = 100;

   // one response beat, field for field
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [VAL_W-1:0]      result_value;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic                  was_update;
      logic                  load_limit_reached;
   } hmap_result_type;

   // Table model plus the queue of responses it has promised.
   class hmap_scoreboard_type;
      bit                slot_used[SLOTS];
      logic [KEY_W-1:0]  slot_key[SLOTS];
      logic [VAL_W-1:0]  slot_value[SLOTS];
      int unsigned       used_count;
      hmap_result_type   promised_q[$];
      int unsigned       mismatches;
      int unsigned       n_hit, n_miss, n_fill, n_update, n_drop;

      function new();
         foreach (slot_used[i]) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
         end
         used_count = 0;
         mismatches = 0;
         n_hit = 0; n_miss = 0; n_fill = 0; n_update = 0; n_drop = 0;
      endfunction

      task report(string what);
         if (mismatches < MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, what);
         mismatches++;
      endtask

      function int unsigned outstanding();
         return promised_q.size();
      endfunction

      // Probe from hash mod SLOTS, wrap once, stop at an empty slot or the same key.
      function void note_request(logic op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash,
                                 logic [VAL_W-1:0] value);
         int unsigned     pos;
         int unsigned     stop_at;
         bit              found;
         hmap_result_type want;
         pos     = hash % SLOTS;
         found   = 1'b0;
         stop_at = 0;
         for (int n = 0; n < SLOTS && !found; n++) begin
            if (!slot_used[pos] || slot_key[pos] == key) begin
               found   = 1'b1;
               stop_at = pos;
            end else begin
               pos = (pos + 1) % SLOTS;
            end
         end
         want        = '0;
         want.status = STATUS_OK;
         if (op == OP_LOOKUP) begin
            if (found && slot_used[stop_at]) begin
               want.result_value = slot_value[stop_at];
               n_hit++;
            end else begin
               want.status = STATUS_MISS;
               n_miss++;
            end
         end else if (!found) begin
            want.status = STATUS_FULL;
            n_drop++;
         end else if (slot_used[stop_at]) begin
            slot_value[stop_at] = value;
            want.was_update     = 1'b1;
            n_update++;
         end else begin
            slot_used[stop_at]  = 1'b1;
            slot_key[stop_at]   = key;
            slot_value[stop_at] = value;
            used_count++;
            n_fill++;
         end
         want.slot_index         = stop_at[SLOT_OUT_W-1:0];
         want.load_limit_reached = (used_count >= LOAD_LIMIT);
         promised_q.push_back(want);
      endfunction

      task check_response(hmap_result_type got);
         hmap_result_type want;
         if (promised_q.size() == 0) begin
            report("response beat with nothing outstanding");
            return;
         end
         want = promised_q.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.result_value !== want.result_value)
            report($sformatf("result_value %h, want %h", got.result_value, want.result_value));
         if (got.slot_index !== want.slot_index)
            report($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
         if (got.was_update !== want.was_update)
            report($sformatf("was_update %b, want %b", got.was_update, want.was_update));
         if (got.load_limit_reached !== want.load_limit_reached)
            report($sformatf("load_limit_reached %b, want %b",
                             got.load_limit_reached, want.load_limit_reached));
      endtask

      task close_out();
         if (promised_q.size() != 0)
            report($sformatf("%0d responses never arrived", promised_q.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   hmap_req_if req_bus ();
   hmap_rsp_if rsp_bus ();

   open_addressing_hash_map #(
      .SLOTS (SLOTS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   hmap_scoreboard_type book = new();

   bit          idling_on;          // both sides may insert random idle bursts
   bit          long_hold_pending;  // ask the response side for one long hold-off
   int unsigned accepted;
   logic [KEY_W-1:0] known_keys[$]; // keys that made it into the table

   // Offer one request beat and wait for the handshake. Must be entered at a rising edge.
   // valid stays high into the next beat unless an idle burst follows.
   task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash,
                               logic [VAL_W-1:0] value);
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.key       <= key;
      req_bus.key_hash  <= hash;
      req_bus.value     <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.note_request(op, key, hash, value);
      accepted++;
      if (idling_on && $urandom_range(0, 99) < 12) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Response side: score every accepted beat, stall in random bursts, and take the
   // one long hold-off when asked. The hold is counted here, in cycles.
   initial begin
      int unsigned     stall_left;
      hmap_result_type got;
      stall_left    = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status             = rsp_bus.status;
            got.result_value       = rsp_bus.result_value;
            got.slot_index         = rsp_bus.slot_index;
            got.was_update         = rsp_bus.was_update;
            got.load_limit_reached = rsp_bus.load_limit_reached;
            book.check_response(got);
         end
         if (stall_left > 0)
            stall_left--;
         else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stall_left        = LONG_HOLD;
         end else if (idling_on && $urandom_range(0, 99) < 8)
            stall_left = $urandom_range(1, 19);
         rsp_bus.ready <= !reset && (stall_left == 0);
      end
   end

   // Stimulus
   initial begin
      int unsigned      pick;
      int unsigned      wait_cycles;
      logic [KEY_W-1:0] key;
      idling_on         = 1'b1;
      long_hold_pending = 1'b0;
      accepted          = 0;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_LOOKUP;
      req_bus.key       <= '0;
      req_bus.key_hash  <= '0;
      req_bus.value     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty table, wrap, key zero, collisions, load limit, full table
      // lookup on an empty table stops at its home slot
      send_request(OP_LOOKUP, 32'h1234_5678, 32'h0000_0003, {VAL_W{1'b1}});
      // key zero is an ordinary key; home slot 15
      send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, {VAL_W{1'b1}});
      known_keys.push_back(32'h0000_0000);
      // same home slot, probe wraps from 15 to 0
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_000F, 64'h0);
      known_keys.push_back(32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_000F, 64'h0);
      send_request(OP_LOOKUP, 32'h0000_0000, 32'hF000_000F, 64'h0);
      // overwrite an existing key
      send_request(OP_INSERT, 32'h0000_0000, 32'h0000_000F, 64'h5555_5555_5555_5555);
      // collides with slot 0, lands in slot 1
      send_request(OP_INSERT, 32'hAAAA_AAAA, 32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
      known_keys.push_back(32'hAAAA_AAAA);
      // miss after walking past two used slots
      send_request(OP_LOOKUP, 32'h5555_5555, 32'h0000_0000, 64'h0);
      // fill the rest; crosses the load limit on the way to full
      for (int i = 0; i < SLOTS - 3; i++) begin
         key = 32'h1000_0000 + i;
         send_request(OP_INSERT, key, {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'(i * 5)},
                      {$urandom, $urandom});
         known_keys.push_back(key);
      end
      // full table: new key is dropped, unknown lookup walks every slot
      send_request(OP_INSERT, 32'h7777_7777, $urandom, {$urandom, $urandom});
      send_request(OP_LOOKUP, 32'h8888_8888, $urandom, 64'h0);

      // --- random: mostly traffic on stored keys, some unknown keys
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idling_on = !(i >= 400 && i < 480) && (i < RANDOM_ITEMS - QUIET_TAIL);
         if (i == HOLD_AT)
            long_hold_pending = 1'b1;
         if (i == DRAIN_AT) begin
            // let the block run dry before going on
            req_bus.valid <= 1'b0;
            while (book.outstanding() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         key  = known_keys[$urandom_range(0, known_keys.size() - 1)];
         if (pick < 40)
            send_request(OP_LOOKUP, key, $urandom, {$urandom, $urandom});
         else if (pick < 70)
            send_request(OP_INSERT, key, $urandom, {$urandom, $urandom});
         else if (pick < 85)
            send_request(OP_LOOKUP, $urandom, $urandom, {$urandom, $urandom});
         else
            send_request(OP_INSERT, $urandom, $urandom, {$urandom, $urandom});
      end

      // --- wind down
      req_bus.valid <= 1'b0;
      wait_cycles = 0;
      while (book.outstanding() != 0 && wait_cycles < 50 * MAX_LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2 * MAX_LATENCY) @(posedge clock);
      book.close_out();

      $display("run: %0d requests: %0d hits, %0d misses, %0d new keys, %0d updates",
               accepted, book.n_hit, book.n_miss, book.n_fill, book.n_update);
      $display("run: %0d inserts dropped on a full table, %0d mismatches",
               book.n_drop, book.mismatches);
      if (book.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog
   initial begin
      #(2 * HALF_PERIOD * 400000);
      $display("timeout: %0d requests accepted, %0d responses outstanding",
               accepted, book.outstanding());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> open_addressing_hash_map.f
+incdir+rtl/core
rtl/core/hmap_pkg.sv
rtl/core/hmap_req_if.sv
rtl/core/hmap_rsp_if.sv
rtl/core/hmap_slot_ram.sv
rtl/core/hmap_prober.sv
rtl/core/open_addressing_hash_map.sv
sim/open_addressing_hash_map_tb.sv
